[sv/quoted_token_lexer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quoted token lexer
// Shared forms for the concurrent checks that sit at the end of the RTL.
// ----------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_LEXER_UNIT_MACROS_SVH
`define QUOTED_TOKEN_LEXER_UNIT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define QTL_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define QTL_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

[sv/qtl_pkg.sv]
// ----------------------------------------------------------------------------
// Quoted token lexer package
// Character codes, status codes, the lexer state type and escape translation.
// ----------------------------------------------------------------------------
package qtl_pkg;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_V      = 8'h76;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_ESCAPE,
        ST_OPEN_ESCAPE,
        ST_OPEN_QUOTE,
        ST_OPEN_COMMENT
    } status_t;

    typedef struct packed {
        logic comment_open;
        logic escape_pending;
        logic quote_open;
        logic quote_is_single;
        logic token_open;
        logic line_stopped;
        logic pending_error;
    } lex_state_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] code;
    } escape_t;

    function automatic escape_t translate_escape(logic [7:0] c);
        escape_t r;
        r.ok   = 1'b1;
        r.code = c;
        unique case (c)
            CH_N:      r.code = 8'd10;
            CH_T:      r.code = 8'd9;
            CH_ZERO:   r.code = 8'd0;
            CH_R:      r.code = 8'd13;
            CH_B:      r.code = 8'd8;
            CH_F:      r.code = 8'd12;
            CH_V:      r.code = 8'd11;
            CH_BSLASH: r.code = CH_BSLASH;
            CH_SQUOTE: r.code = CH_SQUOTE;
            CH_DQUOTE: r.code = CH_DQUOTE;
            default:   r.ok   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[sv/quoted_token_lexer_unit.sv]
// ----------------------------------------------------------------------------
// Quoted token lexer
// Splits a line of characters into tokens, streaming token characters and
// end-of-token markers, with quotes, escapes, comments and error reporting.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                      | tuser                  | tlast
//  s_      | in        | ch                         | -                      | end_of_line
//  m_      | out       | out_char, status, padding  | char_valid, token_end  | line_done
//
// One item is taken per cycle while s_tready is high; its result, if any, appears in
// the output register on the next cycle, and the next item can be taken in that same cycle.
// Only combinational logic lies between the lexer state and the output register.
// aresetn is synchronous and active low and clears the state and the output valid.
// A stall on the result side holds s_tready low only while a result waits.
// ----------------------------------------------------------------------------
`include "quoted_token_lexer_unit_macros.svh"

module quoted_token_lexer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [10:8] status, [15:11] zero
    output logic [1:0]  m_tuser,   // [0] char_valid, [1] token_end
    output logic        m_tlast
);

    qtl_pkg::lex_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          char_reg, char_next;
    logic                char_valid_reg, char_valid_next;
    logic                token_end_reg, token_end_next;
    logic                line_done_reg, line_done_next;
    qtl_pkg::status_t    status_reg, status_next;
    logic                res_valid;
    logic                accept;
    logic [7:0]          c;
    logic                is_quote;
    logic                is_single;
    qtl_pkg::escape_t    esc;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign is_single = (c == qtl_pkg::CH_SQUOTE);
    assign is_quote  = is_single || (c == qtl_pkg::CH_DQUOTE);
    assign esc       = qtl_pkg::translate_escape(c);

    always_comb begin
        state_next      = state_reg;
        res_valid       = 1'b0;
        char_next       = 8'd0;
        char_valid_next = 1'b0;
        token_end_next  = 1'b0;
        line_done_next  = 1'b0;
        status_next     = qtl_pkg::ST_OK;
        if (s_tlast) begin
            res_valid      = 1'b1;
            line_done_next = 1'b1;
            priority if (state_reg.pending_error) begin
                status_next = qtl_pkg::ST_BAD_ESCAPE;
            end else if (state_reg.escape_pending) begin
                status_next = qtl_pkg::ST_OPEN_ESCAPE;
            end else if (state_reg.quote_open) begin
                status_next = qtl_pkg::ST_OPEN_QUOTE;
            end else if (state_reg.comment_open) begin
                status_next = qtl_pkg::ST_OPEN_COMMENT;
            end else begin
                token_end_next = state_reg.token_open;
            end
            state_next = '0;
        end else if (state_reg.line_stopped) begin
            res_valid = 1'b0;
        end else if (state_reg.comment_open) begin
            if (c == qtl_pkg::CH_RPAREN) begin
                state_next.comment_open = 1'b0;
            end
        end else if (state_reg.escape_pending) begin
            state_next.escape_pending = 1'b0;
            if (esc.ok) begin
                res_valid             = 1'b1;
                char_next             = esc.code;
                char_valid_next       = 1'b1;
                state_next.token_open = 1'b1;
            end else begin
                state_next.pending_error = 1'b1;
                state_next.line_stopped  = 1'b1;
            end
        end else if (state_reg.quote_open && c == qtl_pkg::CH_BSLASH) begin
            state_next.escape_pending = 1'b1;
        end else if (!state_reg.quote_open && (c == qtl_pkg::CH_SEMI
                || c == qtl_pkg::CH_LPAREN || c == qtl_pkg::CH_SPACE
                || c == qtl_pkg::CH_TAB)) begin
            if (c == qtl_pkg::CH_SEMI) begin
                state_next.line_stopped = 1'b1;
            end
            if (c == qtl_pkg::CH_LPAREN) begin
                state_next.comment_open = 1'b1;
            end
            res_valid             = state_reg.token_open;
            token_end_next        = 1'b1;
            state_next.token_open = 1'b0;
        end else begin
            if (is_quote) begin
                if (!state_reg.quote_open) begin
                    state_next.quote_open      = 1'b1;
                    state_next.quote_is_single = is_single;
                end else if (state_reg.quote_is_single == is_single) begin
                    state_next.quote_open      = 1'b0;
                    state_next.quote_is_single = 1'b0;
                end
            end
            res_valid             = 1'b1;
            char_next             = c;
            char_valid_next       = 1'b1;
            state_next.token_open = 1'b1;
        end
    end

    assign m_valid_next = s_tready ? (accept && res_valid) : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
        if (accept && res_valid) begin
            char_reg       <= char_next;
            char_valid_reg <= char_valid_next;
            token_end_reg  <= token_end_next;
            line_done_reg  <= line_done_next;
            status_reg     <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, status_reg, char_reg};
    assign m_tuser  = {token_end_reg, char_valid_reg};
    assign m_tlast  = line_done_reg;

    `QTL_ASSERT_ALWAYS(a_status_only_on_line_done,
        !m_valid_reg || line_done_reg || status_reg == qtl_pkg::ST_OK,
        "nonzero status on a result that is not line done")
    `QTL_ASSERT_ALWAYS(a_char_xor_marker,
        !(m_valid_reg && char_valid_reg && token_end_reg),
        "result carries a character and a token end together")
    `QTL_ASSERT_ALWAYS(a_escape_in_quote,
        !state_reg.escape_pending || state_reg.quote_open,
        "escape pending outside a quoted span")
    `QTL_ASSERT_ALWAYS(a_comment_not_quoted,
        !(state_reg.comment_open && state_reg.quote_open),
        "comment and quote open together")
    `QTL_ASSERT_NEXT(a_clear_after_line, accept && s_tlast,
        state_reg == '0 && m_valid_reg && line_done_reg,
        "state not cleared or no result after the end item")

endmodule

[sim/tb_quoted_token_lexer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the quoted token lexer
// Feeds lines of characters, each closed by an end item, through the input
// stream and checks every token character, token close and line status on
// the result stream against a behavioral lexer kept in the testbench. Both
// sides idle at random, with one steady stretch that includes a long result
// stall and pauses that let the lexer drain between phases.
// ----------------------------------------------------------------------------
module tb_quoted_token_lexer_unit;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } line_item_t;

    typedef struct packed {
        logic [7:0]       out_char;
        logic             char_valid;
        logic             token_end;
        logic             line_done;
        qtl_pkg::status_t status;
    } lex_result_t;

    localparam int CLK_HALF      = 5;
    localparam int STALL_CYCLES  = 64;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int IDLE_PERCENT  = 36;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    line_item_t          line_chars[$];
    lex_result_t         awaited_results[$];
    qtl_pkg::lex_state_t lexer = '0;
    int          items_sent   = 0;
    int          items_taken  = 0;
    int          error_count  = 0;
    int          idle_cycles  = 0;
    int          stall_count  = 0;
    bit          steady       = 1'b0;
    bit          want_stall   = 1'b0;

    quoted_token_lexer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // Advances the lexer by one item and returns 1 when the item yields a result.
    function automatic bit lex_char(input logic [7:0] c, input logic eol,
                                    output lex_result_t r);
        logic       esc_ok;
        logic [7:0] esc_code;
        r = '0;
        r.status = qtl_pkg::ST_OK;
        if (eol) begin
            if (lexer.pending_error) r.status = qtl_pkg::ST_BAD_ESCAPE;
            else if (lexer.escape_pending) r.status = qtl_pkg::ST_OPEN_ESCAPE;
            else if (lexer.quote_open) r.status = qtl_pkg::ST_OPEN_QUOTE;
            else if (lexer.comment_open) r.status = qtl_pkg::ST_OPEN_COMMENT;
            r.token_end = (r.status == qtl_pkg::ST_OK) && lexer.token_open;
            r.line_done = 1'b1;
            lexer = '0;
            return 1'b1;
        end
        if (lexer.line_stopped) return 1'b0;
        if (lexer.comment_open) begin
            if (c == qtl_pkg::CH_RPAREN) lexer.comment_open = 1'b0;
            return 1'b0;
        end
        if (lexer.escape_pending) begin
            lexer.escape_pending = 1'b0;
            esc_ok = 1'b1;
            esc_code = c;
            unique case (c)
                qtl_pkg::CH_N:    esc_code = 8'd10;
                qtl_pkg::CH_T:    esc_code = 8'd9;
                qtl_pkg::CH_ZERO: esc_code = 8'd0;
                qtl_pkg::CH_R:    esc_code = 8'd13;
                qtl_pkg::CH_B:    esc_code = 8'd8;
                qtl_pkg::CH_F:    esc_code = 8'd12;
                qtl_pkg::CH_V:    esc_code = 8'd11;
                qtl_pkg::CH_BSLASH, qtl_pkg::CH_SQUOTE, qtl_pkg::CH_DQUOTE: esc_code = c;
                default: esc_ok = 1'b0;
            endcase
            if (!esc_ok) begin
                lexer.pending_error = 1'b1;
                lexer.line_stopped = 1'b1;
                return 1'b0;
            end
            r.out_char = esc_code;
            r.char_valid = 1'b1;
            lexer.token_open = 1'b1;
            return 1'b1;
        end
        if (lexer.quote_open && c == qtl_pkg::CH_BSLASH) begin
            lexer.escape_pending = 1'b1;
            return 1'b0;
        end
        if (!lexer.quote_open &&
            (c == qtl_pkg::CH_SEMI || c == qtl_pkg::CH_LPAREN ||
             c == qtl_pkg::CH_SPACE || c == qtl_pkg::CH_TAB)) begin
            if (c == qtl_pkg::CH_SEMI) lexer.line_stopped = 1'b1;
            if (c == qtl_pkg::CH_LPAREN) lexer.comment_open = 1'b1;
            if (!lexer.token_open) return 1'b0;
            lexer.token_open = 1'b0;
            r.token_end = 1'b1;
            return 1'b1;
        end
        if (c == qtl_pkg::CH_SQUOTE || c == qtl_pkg::CH_DQUOTE) begin
            if (!lexer.quote_open) begin
                lexer.quote_open = 1'b1;
                lexer.quote_is_single = (c == qtl_pkg::CH_SQUOTE);
            end else if (lexer.quote_is_single == (c == qtl_pkg::CH_SQUOTE)) begin
                lexer.quote_open = 1'b0;
                lexer.quote_is_single = 1'b0;
            end
        end
        r.out_char = c;
        r.char_valid = 1'b1;
        lexer.token_open = 1'b1;
        return 1'b1;
    endfunction

    task automatic push_item(input logic [7:0] c, input logic eol);
        line_item_t it;
        it.ch = c;
        it.eol = eol;
        line_chars.insert(line_chars.size(), it);
        items_sent++;
    endtask

    function automatic logic [7:0] escape_char();
        int pick;
        pick = $urandom_range(0, 9);
        unique case (pick)
            0: return qtl_pkg::CH_N;
            1: return qtl_pkg::CH_T;
            2: return qtl_pkg::CH_ZERO;
            3: return qtl_pkg::CH_R;
            4: return qtl_pkg::CH_B;
            5: return qtl_pkg::CH_F;
            6: return qtl_pkg::CH_V;
            7: return qtl_pkg::CH_BSLASH;
            8: return qtl_pkg::CH_SQUOTE;
            default: return qtl_pkg::CH_DQUOTE;
        endcase
    endfunction

    // Builds one line with a bias toward quotes, escapes and separators.
    task automatic push_random_line();
        int         len;
        int         pick;
        logic [7:0] c;
        len = $urandom_range(0, 14);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) c = 8'($urandom_range(8'h61, 8'h7A));
            else if (pick < 38) c = 8'($urandom_range(8'h21, 8'h7E));
            else if (pick < 48)
                c = ($urandom_range(0, 1) != 0) ? qtl_pkg::CH_SPACE : qtl_pkg::CH_TAB;
            else if (pick < 58)
                c = ($urandom_range(0, 1) != 0) ? qtl_pkg::CH_SQUOTE : qtl_pkg::CH_DQUOTE;
            else if (pick < 68) c = qtl_pkg::CH_BSLASH;
            else if (pick < 74) c = qtl_pkg::CH_LPAREN;
            else if (pick < 80) c = qtl_pkg::CH_RPAREN;
            else if (pick < 83) c = qtl_pkg::CH_SEMI;
            else if (pick < 90) c = escape_char();
            else c = 8'($urandom_range(0, 255));
            push_item(c, 1'b0);
            if (c == qtl_pkg::CH_BSLASH && $urandom_range(0, 9) != 0)
                push_item(escape_char(), 1'b0);
        end
        push_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        while (items_taken != items_sent || awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic compare_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : drive
        lex_result_t res;
        line_item_t  it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (lex_char(s_tdata, s_tlast, res))
                    awaited_results.insert(awaited_results.size(), res);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (line_chars.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    it = line_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= it.ch;
                    s_tlast <= it.eol;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        lex_result_t exp_res;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: tdata %0h, tuser %0h, tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    error_count++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    compare_field("out_char", int'(exp_res.out_char), int'(m_tdata[7:0]));
                    compare_field("status", int'(exp_res.status), int'(m_tdata[10:8]));
                    compare_field("char_valid", int'(exp_res.char_valid), int'(m_tuser[0]));
                    compare_field("token_end", int'(exp_res.token_end), int'(m_tuser[1]));
                    compare_field("line_done", int'(exp_res.line_done), int'(m_tlast));
                end
            end
            if (want_stall && stall_count < STALL_CYCLES) begin
                stall_count++;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("quoted_token_lexer_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Byte extremes, tab separator, semicolon that silences the rest of the line.
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(qtl_pkg::CH_TAB, 1'b0);
        push_item("a", 1'b0);
        push_item(qtl_pkg::CH_SEMI, 1'b0);
        push_item("b", 1'b0);
        push_item(8'hFF, 1'b1);
        // Mixed quotes, a newline escape, and a comment left open at the end.
        push_item(qtl_pkg::CH_SQUOTE, 1'b0);
        push_item(qtl_pkg::CH_DQUOTE, 1'b0);
        push_item(qtl_pkg::CH_BSLASH, 1'b0);
        push_item(qtl_pkg::CH_N, 1'b0);
        push_item(qtl_pkg::CH_SQUOTE, 1'b0);
        push_item(qtl_pkg::CH_LPAREN, 1'b0);
        push_item(8'h00, 1'b1);
        // Invalid escape, unfinished escape, and an unclosed quote.
        push_item(qtl_pkg::CH_DQUOTE, 1'b0);
        push_item(qtl_pkg::CH_BSLASH, 1'b0);
        push_item("z", 1'b0);
        push_item(8'h5A, 1'b1);
        push_item(qtl_pkg::CH_DQUOTE, 1'b0);
        push_item(qtl_pkg::CH_BSLASH, 1'b0);
        push_item(8'hA5, 1'b1);
        push_item(qtl_pkg::CH_SQUOTE, 1'b0);
        push_item("a", 1'b0);
        push_item(8'h01, 1'b1);
        wait_drained();

        while (items_sent < 700) push_random_line();
        wait_drained();

        // Steady stretch: no idling, with a long result stall at its start.
        steady = 1'b1;
        want_stall = 1'b1;
        while (items_sent < 1250) push_random_line();
        wait_drained();
        steady = 1'b0;

        while (items_sent < 1850) push_random_line();
        wait_drained();
        repeat (20) @(posedge aclk);

        if (error_count == 0) begin
            $display("quoted_token_lexer_unit: match");
        end else begin
            $display("quoted_token_lexer_unit: mismatch");
        end
        $finish;
    end

endmodule
